// File: hw/rtl/cgde_pkg.sv
// Shared types, widths and codes of the chunked grid delta engine.
package cgde_pkg;

    localparam int DIM_W    = 11;
    localparam int CS_W     = 9;
    localparam int LOC_W    = 8;
    localparam int CIDX_W   = 20;
    localparam int BYTE_W   = 8;
    localparam int CELL_W   = 2;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam int CNT_W    = 2 * DIM_W;
    localparam int DIVD_W   = CIDX_W;
    localparam int DIVS_W   = DIM_W;
    localparam int DIV_STEPS = DIVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int BX_W     = DIM_W + CS_W;
    localparam int X_W      = BX_W + 1;
    localparam int BY_W     = CIDX_W + CS_W;
    localparam int Y_W      = BY_W + 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CELL_W-1:0]    t_cell;
    typedef logic [STAT_W-1:0]    t_status;

    localparam t_cfg_idx CFG_GRID_WIDTH     = 3'd0;
    localparam t_cfg_idx CFG_GRID_HEIGHT    = 3'd1;
    localparam t_cfg_idx CFG_CHUNK_SIZE     = 3'd2;
    localparam t_cfg_idx CFG_OCCUPIED_LEVEL = 3'd3;
    localparam t_cfg_idx CFG_FREE_LEVEL     = 3'd4;

    localparam t_cell CELL_UNKNOWN  = 2'd0;
    localparam t_cell CELL_FREE     = 2'd1;
    localparam t_cell CELL_OCCUPIED = 2'd2;

    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_SKIPPED   = 2'd1;
    localparam t_status ST_BAD_CHUNK = 2'd2;

endpackage

// File: hw/rtl/cgde_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module cgde_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cgde_pkg::DIVD_W-1:0] i_dividend,
    input  logic [cgde_pkg::DIVS_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [cgde_pkg::DIVD_W-1:0] o_quotient,
    output logic [cgde_pkg::DIVS_W-1:0] o_remainder
);
    import cgde_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVD_W-1:0]    r_quo;
    logic [DIVS_W-1:0]    r_rem;
    logic [DIVS_W-1:0]    r_div;
    logic [DIVS_W:0]      w_trial;
    logic                 w_fit;

    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIVD_W-2:0], w_fit};
                r_rem <= w_fit ? DIVS_W'(w_trial - {1'b0, r_div}) : w_trial[DIVS_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != '0) |-> !i_start)
        else $error("divider restarted while busy");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");
`endif

endmodule

// File: hw/rtl/chunked_grid_delta_engine.sv
// Chunked occupancy grid engine: applies or extracts one cell per request.
// A request whose chunk index equals that of the previous request passes through
// S_CHK, S_POS, S_ADDR, S_MEM and S_DONE (plus S_RD in extract mode, for the
// registered memory read); the next request is accepted back in S_IDLE. A new
// chunk index adds one pass of the shared 20-step divider and the base multiply;
// after a write of grid_width, grid_height or chunk_size the first request adds
// the two chunk-count divisions. An invalid chunk size goes straight to S_DONE.
// After reset the cell memory is cleared one entry per cycle over all
// MAX_WIDTH*MAX_HEIGHT entries; requests stall meanwhile, config writes do not.
module chunked_grid_delta_engine #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_CHUNK  = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cgde_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cgde_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic [cgde_pkg::CIDX_W-1:0]    i_chunk_index,
    input  logic signed [cgde_pkg::BYTE_W-1:0] i_cell_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [cgde_pkg::CELL_W-1:0]    o_cell_state,
    output logic [cgde_pkg::STAT_W-1:0]    o_status,
    output logic                           o_chunk_done
);
    import cgde_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XA_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YA_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GX   = 4'd1;
    localparam logic [3:0] S_GY   = 4'd2;
    localparam logic [3:0] S_CNT  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_CDIV = 4'd5;
    localparam logic [3:0] S_BASE = 4'd6;
    localparam logic [3:0] S_POS  = 4'd7;
    localparam logic [3:0] S_ADDR = 4'd8;
    localparam logic [3:0] S_MEM  = 4'd9;
    localparam logic [3:0] S_RD   = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    // configuration
    logic [DIM_W-1:0]         r_grid_width;
    logic [DIM_W-1:0]         r_grid_height;
    logic [CS_W-1:0]          r_chunk_size;
    logic signed [BYTE_W-1:0] r_occ_level;
    logic signed [BYTE_W-1:0] r_free_level;

    // control
    logic [3:0]        r_state;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_geom_ok;
    logic              r_chunk_ok;
    logic [LOC_W-1:0]  r_local_col;
    logic [LOC_W-1:0]  r_local_row;
    logic              r_div_start;
    logic              r_out_valid;

    // working payload
    logic                     r_mode;
    logic [CIDX_W-1:0]        r_cidx;
    logic signed [BYTE_W-1:0] r_byte;
    logic [CIDX_W-1:0]        r_last_cidx;
    logic [DIM_W-1:0]         r_cx;
    logic [DIM_W-1:0]         r_cy;
    logic [CNT_W-1:0]         r_count;
    logic [DIM_W-1:0]         r_cc;
    logic [CIDX_W-1:0]        r_cr;
    logic [BX_W-1:0]          r_base_x;
    logic [BY_W-1:0]          r_base_y;
    logic [X_W-1:0]           r_x;
    logic [Y_W-1:0]           r_y;
    logic [ADDR_W-1:0]        r_addr;
    logic [DIVD_W-1:0]        r_div_a;
    logic [DIVS_W-1:0]        r_div_b;
    t_cell                    r_res_cell;
    t_status                  r_res_status;
    logic                     r_res_adv;
    logic                     r_res_done;
    t_cell                    r_rdata;
    t_cell                    r_out_cell;
    t_status                  r_out_status;
    logic                     r_out_done;

    t_cell r_mem [DEPTH];

    logic               w_accept;
    logic [DIM_W-1:0]   w_w;
    logic [DIM_W-1:0]   w_h;
    logic               w_cs_ok;
    logic               w_wrap_col;
    logic               w_wrap_row;
    t_cell              w_dec;
    logic               w_out_free;
    logic               w_mem_we;
    logic [ADDR_W-1:0]  w_mem_addr;
    t_cell              w_mem_wdata;
    logic               w_div_busy;
    logic               w_div_done;
    logic [DIVD_W-1:0]  w_div_q;
    logic [DIVS_W-1:0]  w_div_r;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_clearing;
    assign w_w = (32'(r_grid_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : r_grid_width;
    assign w_h = (32'(r_grid_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : r_grid_height;
    assign w_cs_ok    = (r_chunk_size != '0) && (32'(r_chunk_size) <= MAX_CHUNK);
    assign w_wrap_col = (CS_W'(r_local_col) + CS_W'(1)) >= r_chunk_size;
    assign w_wrap_row = (CS_W'(r_local_row) + CS_W'(1)) >= r_chunk_size;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_byte >= r_occ_level) begin
            w_dec = CELL_OCCUPIED;
        end else if (r_byte == r_free_level) begin
            w_dec = CELL_FREE;
        end else begin
            w_dec = CELL_UNKNOWN;
        end
    end

    cgde_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_q),
        .o_remainder(w_div_r)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= DIM_W'(1024);
            r_grid_height <= DIM_W'(1024);
            r_chunk_size  <= CS_W'(16);
            r_occ_level   <= BYTE_W'(100);
            r_free_level  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH:     r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT:    r_grid_height <= i_cfg_data;
                CFG_CHUNK_SIZE:     r_chunk_size  <= i_cfg_data[CS_W-1:0];
                CFG_OCCUPIED_LEVEL: r_occ_level   <= i_cfg_data[BYTE_W-1:0];
                CFG_FREE_LEVEL:     r_free_level  <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_geom_ok   <= 1'b0;
            r_chunk_ok  <= 1'b0;
            r_local_col <= '0;
            r_local_row <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;

            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we && (i_cfg_idx == CFG_GRID_WIDTH || i_cfg_idx == CFG_GRID_HEIGHT
                             || i_cfg_idx == CFG_CHUNK_SIZE)) begin
                r_geom_ok  <= 1'b0;
                r_chunk_ok <= 1'b0;
            end
            if (i_cfg_we && i_cfg_idx == CFG_CHUNK_SIZE) begin
                r_local_col <= '0;
                r_local_row <= '0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode <= i_mode;
                        r_cidx <= i_chunk_index;
                        r_byte <= i_cell_value;
                        if (!w_cs_ok) begin
                            r_res_cell   <= CELL_UNKNOWN;
                            r_res_status <= ST_BAD_CHUNK;
                            r_res_adv    <= 1'b0;
                            r_state      <= S_DONE;
                        end else if (!r_geom_ok) begin
                            r_div_a     <= DIVD_W'({1'b0, w_w} + {3'b0, r_chunk_size}
                                                   - 12'd1);
                            r_div_b     <= DIVS_W'(r_chunk_size);
                            r_div_start <= 1'b1;
                            r_state     <= S_GX;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_GX: begin
                    if (w_div_done) begin
                        r_cx        <= w_div_q[DIM_W-1:0];
                        r_div_a     <= DIVD_W'({1'b0, w_h} + {3'b0, r_chunk_size} - 12'd1);
                        r_div_b     <= DIVS_W'(r_chunk_size);
                        r_div_start <= 1'b1;
                        r_state     <= S_GY;
                    end
                end
                S_GY: begin
                    if (w_div_done) begin
                        r_cy    <= w_div_q[DIM_W-1:0];
                        r_state <= S_CNT;
                    end
                end
                S_CNT: begin
                    r_count   <= CNT_W'(r_cx) * CNT_W'(r_cy);
                    r_geom_ok <= 1'b1;
                    r_state   <= S_CHK;
                end
                S_CHK: begin
                    if (r_cx == '0 || CNT_W'(r_cidx) >= r_count) begin
                        r_res_cell   <= CELL_UNKNOWN;
                        r_res_status <= ST_BAD_CHUNK;
                        r_res_adv    <= 1'b1;
                        r_state      <= S_DONE;
                    end else if (r_chunk_ok && r_cidx == r_last_cidx) begin
                        r_state <= S_POS;
                    end else begin
                        r_div_a     <= r_cidx;
                        r_div_b     <= r_cx;
                        r_div_start <= 1'b1;
                        r_state     <= S_CDIV;
                    end
                end
                S_CDIV: begin
                    if (w_div_done) begin
                        r_cc    <= w_div_r;
                        r_cr    <= w_div_q;
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_base_x    <= BX_W'(r_cc) * BX_W'(r_chunk_size);
                    r_base_y    <= BY_W'(r_cr) * BY_W'(r_chunk_size);
                    r_last_cidx <= r_cidx;
                    r_chunk_ok  <= 1'b1;
                    r_state     <= S_POS;
                end
                S_POS: begin
                    r_x     <= X_W'(r_base_x) + X_W'(r_local_col);
                    r_y     <= Y_W'(r_base_y) + Y_W'(r_local_row);
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    if (r_x >= X_W'(w_w) || r_y >= Y_W'(w_h)) begin
                        r_res_cell   <= CELL_UNKNOWN;
                        r_res_status <= ST_SKIPPED;
                        r_res_adv    <= 1'b1;
                        r_state      <= S_DONE;
                    end else begin
                        r_addr  <= ADDR_W'(r_y[YA_W-1:0]) * ADDR_W'(MAX_WIDTH)
                                   + ADDR_W'(r_x[XA_W-1:0]);
                        r_state <= S_MEM;
                    end
                end
                S_MEM: begin
                    r_res_status <= ST_DONE;
                    r_res_adv    <= 1'b1;
                    if (!r_mode) begin
                        r_res_cell <= w_dec;
                        r_state    <= S_DONE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_res_cell <= r_rdata;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_cell   <= r_res_cell;
                        r_out_status <= r_res_status;
                        r_out_done   <= r_res_adv && w_wrap_col && w_wrap_row;
                        if (r_res_adv) begin
                            if (w_wrap_col) begin
                                r_local_col <= '0;
                                r_local_row <= w_wrap_row ? '0 : r_local_row + 1'b1;
                            end else begin
                                r_local_col <= r_local_col + 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // cell memory
    assign w_mem_we    = r_clearing || (r_state == S_MEM && !r_mode);
    assign w_mem_addr  = r_clearing ? r_clr_addr : r_addr;
    assign w_mem_wdata = r_clearing ? CELL_UNKNOWN : w_dec;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_state = r_out_cell;
    assign o_status     = r_out_status;
    assign o_chunk_done = r_out_done;

`ifndef SYNTHESIS
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside the completion step");
    a_mem_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEM) |-> (r_x < X_W'(w_w) && r_y < Y_W'(w_h)))
        else $error("memory access outside the grid");
    a_col_below_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cs_ok |-> (CS_W'(r_local_col) < r_chunk_size && CS_W'(r_local_row) < r_chunk_size))
        else $error("chunk position counter beyond chunk size");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> !w_div_busy)
        else $error("divider started while busy");
    a_clear_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (r_state == S_IDLE && !o_out_valid))
        else $error("request in flight during memory clear");
`endif

endmodule
